>>> src/mbc_pkg.sv
// Shared types and constants for the masked barrier coordinator.
// No dependencies; imported by the top level.
`default_nettype none
package mbc_pkg;

  localparam int unsigned MASK_W    = 32;
  localparam int unsigned NODE_W    = 5;
  localparam int unsigned NCNT_W    = 6;
  localparam int unsigned MAX_NODES = 32;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = NCNT_W'(32);
  localparam logic [NODE_W-1:0] LAST_BIT       = NODE_W'(MASK_W - 1);

  localparam logic STATUS_RELEASE = 1'b0;
  localparam logic STATUS_FULL    = 1'b1;

  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [NCNT_W-1:0] ncnt_t;

  // one table row: barrier mask plus the set of nodes that have arrived
  typedef struct packed {
    mask_t mask;
    mask_t arrived;
  } entry_t;

endpackage
`default_nettype wire

>>> src/mbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mbc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/masked_barrier_coordinator_top.sv
// Masked barrier coordinator: sequencer, barrier table and release walker.
// Depends on mbc_pkg and mbc_ram.
//
// Usage:
//   Request: drive in_barrier_mask / in_arriving_node with start high while
//   busy is low; the request is taken on that edge and busy rises next cycle.
//   Results: each appears for one cycle with out_valid high; out_last marks
//   the final result of a request. The receiver cannot stall the block.
//   Config: cfg_we with cfg_wdata writes node_count; write only while idle.
// Steps per request:
//   table search: one RAM read per cycle through the single read port, each
//   entry compared once its registered read data returns; a miss allocates
//   the next free entry, and a table-full miss ends there with one result.
//   popcount: one bit per cycle into the arrived and participant counters.
//   update: table write. Release walk (only when the barrier completes):
//   node indices in order up to the highest released node, one result per
//   participating node below node_count.
// Reset clears the table fill count (all entries free), the sequencer and
// node_count (to 32). Table rows are written on allocation, so no clearing.
`default_nettype none
module masked_barrier_coordinator_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire mbc_pkg::mask_t in_barrier_mask,
  input  wire mbc_pkg::node_t in_arriving_node,
  output logic                out_valid,
  output logic                out_status,
  output mbc_pkg::node_t      out_target_node,
  output mbc_pkg::mask_t      out_released_mask,
  output logic                out_last,
  input  wire logic           cfg_we,
  input  wire mbc_pkg::ncnt_t cfg_wdata
);
  import mbc_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] TableFull = CW'(TABLE_ENTRIES);
  localparam int unsigned EW = $bits(entry_t);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_COUNT  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  mask_t         mask_r, mask_nxt;
  node_t         node_r, node_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  mask_t         arr_r, arr_nxt;
  node_t         bit_r, bit_nxt;
  ncnt_t         pa_r, pa_nxt;
  ncnt_t         pm_r, pm_nxt;
  mask_t         rem_r, rem_nxt;
  ncnt_t         node_count_r;

  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  node_t         out_target_r, out_target_nxt;
  mask_t         out_mask_r, out_mask_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_we, ram_re;
  logic [EW-1:0] ram_wdata, ram_rdata;
  entry_t        rd_entry, wr_entry;

  ncnt_t         limit;
  mask_t         low_mask;
  mask_t         node_bit, bit_sel, rem_left;
  logic          hit, complete;

  mbc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign ram_wdata = EW'(wr_entry);

  assign limit = (node_count_r > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_r;

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      low_mask[i] = (NCNT_W'(i) < limit);
    end
  end

  assign node_bit = mask_t'(1) << node_r;
  assign bit_sel  = mask_t'(1) << bit_r;
  assign rem_left = rem_r & ~bit_sel;
  assign hit      = cmp_v_r && (rd_entry.mask == mask_r);
  // arrived count reached participant count
  assign complete = (pa_r >= pm_r);

  always_comb begin
    state_nxt      = state_r;
    mask_nxt       = mask_r;
    node_nxt       = node_r;
    fill_nxt       = fill_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    slot_nxt       = slot_r;
    arr_nxt        = arr_r;
    bit_nxt        = bit_r;
    pa_nxt         = pa_r;
    pm_nxt         = pm_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_target_nxt = out_target_r;
    out_mask_nxt   = out_mask_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    wr_entry.mask    = mask_r;
    wr_entry.arrived = complete ? '0 : arr_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mask_nxt     = in_barrier_mask;
          node_nxt     = in_arriving_node;
          scan_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          slot_nxt  = cmp_idx_r;
          arr_nxt   = rd_entry.arrived | node_bit;
          bit_nxt   = '0;
          pa_nxt    = '0;
          pm_nxt    = '0;
          state_nxt = ST_COUNT;
        end else if (scan_idx_r == fill_r) begin
          if (fill_r == TableFull) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_FULL;
            out_target_nxt = '0;
            out_mask_nxt   = mask_r;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            // entries fill from the bottom and are never freed
            slot_nxt  = fill_r[AW-1:0];
            fill_nxt  = fill_r + CW'(1);
            arr_nxt   = node_bit;
            bit_nxt   = '0;
            pa_nxt    = '0;
            pm_nxt    = '0;
            state_nxt = ST_COUNT;
          end
        end else begin
          ram_re       = 1'b1;
          cmp_v_nxt    = 1'b1;
          cmp_idx_nxt  = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
      end
      ST_COUNT: begin
        pa_nxt  = pa_r + NCNT_W'(arr_r[bit_r]);
        pm_nxt  = pm_r + NCNT_W'(mask_r[bit_r]);
        bit_nxt = bit_r + NODE_W'(1);
        if (bit_r == LAST_BIT) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ram_we    = 1'b1;
        state_nxt = ST_IDLE;
        if (complete) begin
          rem_nxt = mask_r & low_mask;
          bit_nxt = '0;
          if ((mask_r & low_mask) != '0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        bit_nxt = bit_r + NODE_W'(1);
        if (rem_r[bit_r]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_RELEASE;
          out_target_nxt = bit_r;
          out_mask_nxt   = mask_r;
          out_last_nxt   = (rem_left == '0);
          rem_nxt        = rem_left;
          if (rem_left == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      cmp_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      node_count_r <= NODE_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mask_r       <= mask_nxt;
    node_r       <= node_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    slot_r       <= slot_nxt;
    arr_r        <= arr_nxt;
    bit_r        <= bit_nxt;
    pa_r         <= pa_nxt;
    pm_r         <= pm_nxt;
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_target_r <= out_target_nxt;
    out_mask_r   <= out_mask_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_target_node   = out_target_r;
  assign out_released_mask = out_mask_r;
  assign out_last          = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TableFull)
    else $error("table fill count beyond table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but sequencer not busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("sequencer still busy after final result");

  a_full_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FULL) |-> (out_last && out_target_node == '0))
    else $error("table-full result malformed");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

endmodule
`default_nettype wire

>>> dv/masked_barrier_coordinator_top_tb.sv
// Self-checking testbench for masked_barrier_coordinator_top: directed table, then random arrivals.
// Depends on mbc_pkg and the coordinator RTL. The predictor models the barrier table here.
`default_nettype none
module masked_barrier_coordinator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbc_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 148;

  typedef struct packed {
    logic  status;
    node_t target;
    mask_t mask;
    logic  last;
  } release_t;

  typedef enum logic {ROW_ARRIVE, ROW_NODE_COUNT} row_kind_t;

  // typed rows carry their own expectation: none, or one release to typed_target
  typedef struct packed {
    row_kind_t kind;
    mask_t     mask;
    node_t     node;
    ncnt_t     count;
    logic      typed;
    logic      typed_one;
    node_t     typed_target;
  } stim_row_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  mask_t in_barrier_mask;
  node_t in_arriving_node;
  logic  out_valid;
  logic  out_status;
  node_t out_target_node;
  mask_t out_released_mask;
  logic  out_last;
  logic  cfg_we;
  ncnt_t cfg_wdata;

  // predictor state
  logic        slot_used [ENTRIES];
  mask_t       slot_mask [ENTRIES];
  mask_t       slot_arrived [ENTRIES];
  int unsigned slots_taken;
  ncnt_t       node_count_cfg;

  release_t    pending_releases[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;

  stim_row_t dir_rows [19] = '{
    '{ROW_ARRIVE,     32'h0000_0001, 5'd0,  6'd0,  1'b1, 1'b1, 5'd0},
    '{ROW_ARRIVE,     32'h8000_0000, 5'd31, 6'd0,  1'b1, 1'b1, 5'd31},
    '{ROW_ARRIVE,     32'h0000_0000, 5'd5,  6'd0,  1'b1, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0006, 5'd9,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0006, 5'd2,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'hFFFF_FFFF, 5'd17, 6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_NODE_COUNT, 32'h0000_0000, 5'd0,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0001, 5'd0,  6'd0,  1'b1, 1'b0, 5'd0},
    '{ROW_NODE_COUNT, 32'h0000_0000, 5'd0,  6'd4,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0030, 5'd4,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0030, 5'd5,  6'd0,  1'b1, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_000A, 5'd3,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_000A, 5'd1,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_NODE_COUNT, 32'h0000_0000, 5'd0,  6'd63, 1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h8000_0001, 5'd31, 6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h8000_0001, 5'd0,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0006, 5'd6,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0006, 5'd6,  6'd0,  1'b0, 1'b0, 5'd0},
    '{ROW_ARRIVE,     32'h0000_0006, 5'd1,  6'd0,  1'b0, 1'b0, 5'd0}
  };

  masked_barrier_coordinator_top #(.TABLE_ENTRIES(ENTRIES)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_barrier_mask  (in_barrier_mask),
    .in_arriving_node (in_arriving_node),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_target_node  (out_target_node),
    .out_released_mask(out_released_mask),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void enqueue_release(input release_t r);
    pending_releases = {pending_releases, r};
  endfunction

  // Barrier table update for one accepted arrival; queues the releases when keep is set.
  task automatic compute_releases(input mask_t m, input node_t n, input bit keep);
    int          hit;
    int          free_slot;
    int unsigned reach;
    release_t    batch[$];
    release_t    r;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_mask[i] == m) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        r = '{STATUS_FULL, node_t'(0), m, 1'b1};
        if (keep) enqueue_release(r);
        return;
      end
      hit = free_slot;
      slot_used[hit] = 1'b1;
      slot_mask[hit] = m;
      slot_arrived[hit] = '0;
      slots_taken++;
    end
    slot_arrived[hit][n] = 1'b1;
    if ($countones(slot_arrived[hit]) >= $countones(m)) begin
      reach = (node_count_cfg > MAX_NODES) ? MAX_NODES : node_count_cfg;
      for (int unsigned ni = 0; ni < reach; ni++) begin
        if (m[ni]) begin
          r = '{STATUS_RELEASE, node_t'(ni), m, 1'b0};
          batch = {batch, r};
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      if (keep) begin
        foreach (batch[k]) enqueue_release(batch[k]);
      end
      slot_arrived[hit] = '0;
    end
  endtask

  // Drive one request and hold it until the block takes it.
  task automatic send_arrival(input mask_t m, input node_t n, input bit keep);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_barrier_mask  <= m;
    in_arriving_node <= n;
    do @(posedge clk); while (busy);
    compute_releases(m, n, keep);
  endtask

  task automatic write_node_count(input ncnt_t v);
    start <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk);
    // zero-result requests can still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_cfg = v;
  endtask

  function automatic mask_t fresh_mask();
    mask_t m;
    m = '0;
    if ($urandom_range(0, 9) == 0) begin
      m = $urandom();
    end else begin
      repeat ($urandom_range(1, 5)) m[$urandom_range(0, 31)] = 1'b1;
    end
    return m;
  endfunction

  function automatic mask_t known_mask();
    return slot_mask[$urandom_range(0, slots_taken - 1)];
  endfunction

  // Mostly complete barrier rounds from shuffled members, with stray and cut-short rounds.
  task automatic run_phase(input int unsigned items, input int unsigned idle_pct,
                           input bit lead_all_ones);
    int unsigned sent;
    int unsigned pick;
    int unsigned stop_at;
    int unsigned j;
    mask_t       m;
    node_t       order[$];
    node_t       tmp;
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (lead_all_ones) begin
        pick = 99;
        m = '1;
        lead_all_ones = 1'b0;
      end else if (pick >= 12 && pick < 32 && slots_taken < ENTRIES) begin
        m = fresh_mask();
      end else if (pick < 12 && slots_taken == ENTRIES && $urandom_range(0, 1)) begin
        m = $urandom();
      end else begin
        m = known_mask();
      end
      if (pick < 12) begin
        send_arrival(m, node_t'($urandom_range(0, 31)), 1'b1);
        sent++;
      end else begin
        order.delete();
        for (int k = 0; k < 32; k++) if (m[k]) order = {order, node_t'(k)};
        if (order.size() == 0) order = {order, node_t'($urandom_range(0, 31))};
        for (int k = order.size() - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, order.size()) : order.size();
        for (int k = 0; k < stop_at; k++) begin
          if ($urandom_range(0, 99) < 8) begin
            send_arrival(m, node_t'($urandom_range(0, 31)), 1'b1);
            sent++;
          end
          send_arrival(m, order[k], 1'b1);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    release_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_releases.size() == 0) begin
        $error("unexpected result: target %0d mask %h", out_target_node, out_released_mask);
        mismatch_count++;
      end else begin
        exp_r = pending_releases.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          mismatch_count++;
        end
        if (out_target_node !== exp_r.target) begin
          $error("target_node: expected %0d, got %0d", exp_r.target, out_target_node);
          mismatch_count++;
        end
        if (out_released_mask !== exp_r.mask) begin
          $error("released_mask: expected %h, got %h", exp_r.mask, out_released_mask);
          mismatch_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** masked_barrier_coordinator_top: FAILED **");
      $finish;
    end
  end

  initial begin
    release_t typed_r;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_barrier_mask  <= '0;
    in_arriving_node <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    slots_taken    = 0;
    node_count_cfg = NODE_COUNT_RST;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i]    = 1'b0;
      slot_mask[i]    = '0;
      slot_arrived[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_NODE_COUNT) begin
        write_node_count(dir_rows[r].count);
      end else begin
        send_arrival(dir_rows[r].mask, dir_rows[r].node, !dir_rows[r].typed);
        if (dir_rows[r].typed && dir_rows[r].typed_one) begin
          typed_r = '{STATUS_RELEASE, dir_rows[r].typed_target, dir_rows[r].mask, 1'b1};
          enqueue_release(typed_r);
        end
      end
    end

    write_node_count(ncnt_t'(32));
    run_phase(PHASE_ITEMS, 35, 1'b1);
    write_node_count(ncnt_t'(1));
    run_phase(PHASE_ITEMS, 87, 1'b0);
    write_node_count(ncnt_t'($urandom_range(2, 31)));
    run_phase(PHASE_ITEMS, 0, 1'b0);

    start <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_releases.size() == 0) begin
      $display("** masked_barrier_coordinator_top: PASSED **");
    end else begin
      $display("** masked_barrier_coordinator_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
src/mbc_pkg.sv
src/mbc_ram.sv
src/masked_barrier_coordinator_top.sv
dv/masked_barrier_coordinator_top_tb.sv
